// File: sv/knob_value_to_key_and_wheel_events_macros.svh
// Assertion helpers used by the checker file.
`ifndef KNOB_VALUE_TO_KEY_AND_WHEEL_EVENTS_MACROS_SVH
`define KNOB_VALUE_TO_KEY_AND_WHEEL_EVENTS_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define KVKW_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define KVKW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/kvkw_pkg.sv
`timescale 1ns / 1ps

package kvkw_pkg;

    localparam int SAMPLE_W   = 7;
    localparam int ACC_W      = 8;
    localparam int WORK_W     = 10;   // accumulator plus one signed delta
    localparam int MAX_EVENTS = 64;
    localparam int CNT_W      = 7;
    localparam int ADDR_W     = 3;
    localparam int CFG_DATA_W = 8;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    // Register indexes of the configuration port
    localparam logic [ADDR_W-1:0] REG_MODE         = 3'd0;
    localparam logic [ADDR_W-1:0] REG_LOW_LEVEL    = 3'd1;
    localparam logic [ADDR_W-1:0] REG_HIGH_LEVEL   = 3'd2;
    localparam logic [ADDR_W-1:0] REG_INVERT_WHEEL = 3'd3;
    localparam logic [ADDR_W-1:0] REG_WHEEL_STEP   = 3'd4;
    localparam logic [ADDR_W-1:0] REG_TAP_STEP     = 3'd5;

    localparam logic [SAMPLE_W-1:0] MIN_STEP = 7'd2;

    typedef enum logic [1:0] {
        MODE_NONE, MODE_THRESH, MODE_WHEEL, MODE_TAP
    } mode_t;

    typedef enum logic [0:0] {
        OP_SAMPLE, OP_RELEASE
    } op_t;

    typedef enum logic [1:0] {
        EV_PRESS, EV_RELEASE, EV_TAP, EV_WHEEL
    } event_kind_t;

    typedef enum logic [1:0] {
        SLOT_LOW, SLOT_HIGH, SLOT_INC, SLOT_DEC
    } key_slot_t;

    typedef enum logic [1:0] {
        CMD_RELEASE, CMD_THRESH, CMD_WHEEL, CMD_TAP
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE, BK_KEYS, BK_MOVE
    } back_state_t;

    // Classified item handed from front to back
    typedef struct packed {
        cmd_kind_t           kind;
        logic [SAMPLE_W-1:0] value;
    } cmd_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        mode_t               mode;
        logic [7:0]          low_level;
        logic [SAMPLE_W-1:0] high_level;
        logic                invert_wheel;
        logic [SAMPLE_W-1:0] wheel_step;
        logic [SAMPLE_W-1:0] tap_step;
    } cfg_t;

endpackage

// File: sv/kvkw_front.sv
`timescale 1ns / 1ps

module kvkw_front import kvkw_pkg::*; (
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [6:0] sample_value, [7] zero
    input  logic       s_tuser,     // [0] operation
    input  mode_t      mode,
    input  q_status_t  q_status,
    output logic       q_push,
    output cmd_t       q_wdata
);

    logic accepted;

    // Take an item whenever the queue has room
    assign s_tready = !q_status.full;
    assign accepted = s_tvalid && !q_status.full;

    // Classify: release in any mode, samples by mode; mode none drops samples
    always_comb begin
        q_wdata.value = s_tdata[SAMPLE_W-1:0];
        q_push        = 1'b0;
        q_wdata.kind  = CMD_RELEASE;
        if (s_tuser == OP_RELEASE) begin
            q_push = accepted;
        end else begin
            case (mode)
                MODE_THRESH: begin
                    q_wdata.kind = CMD_THRESH;
                    q_push       = accepted;
                end
                MODE_WHEEL: begin
                    q_wdata.kind = CMD_WHEEL;
                    q_push       = accepted;
                end
                MODE_TAP: begin
                    q_wdata.kind = CMD_TAP;
                    q_push       = accepted;
                end
                default: begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

endmodule

// File: sv/kvkw_cmd_fifo.sv
`timescale 1ns / 1ps

module kvkw_cmd_fifo import kvkw_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cmd_t      wdata,
    input  logic      pop,
    output cmd_t      rdata,
    output q_status_t status
);

    cmd_t                mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_CNT_W-1:0]  count_reg;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = mem[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: sv/kvkw_back.sv
`timescale 1ns / 1ps

module kvkw_back import kvkw_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       cfg_clear,
    input  q_status_t  q_status,
    input  cmd_t       q_rdata,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [1:0] key_slot, [2] wheel_up, [7:3] zero
    output logic [1:0] m_tuser,     // [1:0] event_kind
    output logic       m_tlast      // last_of_run
);

    back_state_t               state_reg, state_next;
    logic                      low_held_reg, low_held_next;
    logic                      high_held_reg, high_held_next;
    logic                      base_valid_reg, base_valid_next;
    logic [SAMPLE_W-1:0]       base_reg, base_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [WORK_W-1:0]  work_reg, work_next;
    logic                      wheel_reg, wheel_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      pend_low_reg, pend_low_next;
    logic                      pend_high_reg, pend_high_next;
    event_kind_t               low_kind_reg, low_kind_next;
    event_kind_t               high_kind_reg, high_kind_next;

    logic                      out_valid_reg;
    event_kind_t               out_kind_reg;
    key_slot_t                 out_slot_reg;
    logic                      out_up_reg;
    logic                      out_last_reg;

    logic                      emit;
    event_kind_t               ev_kind;
    key_slot_t                 ev_slot;
    logic                      ev_up;
    logic                      ev_last;

    logic [SAMPLE_W-1:0]       step_raw;
    logic signed [WORK_W-1:0]  step_w;
    logic signed [WORK_W-1:0]  work_sub;
    logic signed [WORK_W-1:0]  work_add;
    logic signed [WORK_W-1:0]  work_add2;
    logic signed [WORK_W-1:0]  sum;
    logic                      pos_go;
    logic                      neg_go;
    logic                      cap_last;
    logic                      out_free;
    logic                      low_wanted;
    logic                      high_wanted;

    // Effective step, small steps saturate to two
    assign step_raw = wheel_reg ? cfg.wheel_step : cfg.tap_step;
    assign step_w   = (step_raw < MIN_STEP) ? WORK_W'(MIN_STEP) : WORK_W'(step_raw);
    assign work_sub = work_reg - step_w;
    assign work_add = work_reg + step_w;
    assign work_add2 = work_add + step_w;
    assign pos_go   = (work_reg >= step_w) && (cnt_reg != CNT_W'(MAX_EVENTS));
    assign neg_go   = (work_add <= 0) && (cnt_reg != CNT_W'(MAX_EVENTS));
    assign cap_last = (cnt_reg == CNT_W'(MAX_EVENTS - 1));
    assign out_free = !out_valid_reg || m_tready;

    // Threshold compares and the new movement sum for the head item
    assign low_wanted  = {1'b0, q_rdata.value} < cfg.low_level;
    assign high_wanted = q_rdata.value > cfg.high_level;
    assign sum = WORK_W'(acc_reg) + $signed(WORK_W'(q_rdata.value))
               - $signed(WORK_W'(base_reg));

    // Sequencer: next state, tracking state and the event to emit
    always_comb begin
        state_next      = state_reg;
        low_held_next   = low_held_reg;
        high_held_next  = high_held_reg;
        base_valid_next = base_valid_reg;
        base_next       = base_reg;
        acc_next        = acc_reg;
        work_next       = work_reg;
        wheel_next      = wheel_reg;
        cnt_next        = cnt_reg;
        pend_low_next   = pend_low_reg;
        pend_high_next  = pend_high_reg;
        low_kind_next   = low_kind_reg;
        high_kind_next  = high_kind_reg;
        q_pop           = 1'b0;
        emit            = 1'b0;
        ev_kind         = EV_PRESS;
        ev_slot         = SLOT_LOW;
        ev_up           = 1'b0;
        ev_last         = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty) begin
                    q_pop = 1'b1;
                    case (q_rdata.kind)
                        CMD_RELEASE: begin
                            pend_low_next   = low_held_reg;
                            pend_high_next  = high_held_reg;
                            low_kind_next   = EV_RELEASE;
                            high_kind_next  = EV_RELEASE;
                            low_held_next   = 1'b0;
                            high_held_next  = 1'b0;
                            base_valid_next = 1'b0;
                            acc_next        = '0;
                            if (low_held_reg || high_held_reg) begin
                                state_next = BK_KEYS;
                            end
                        end
                        CMD_THRESH: begin
                            pend_low_next   = low_wanted != low_held_reg;
                            pend_high_next  = high_wanted != high_held_reg;
                            low_kind_next   = low_wanted ? EV_PRESS : EV_RELEASE;
                            high_kind_next  = high_wanted ? EV_PRESS : EV_RELEASE;
                            low_held_next   = low_wanted;
                            high_held_next  = high_wanted;
                            base_valid_next = 1'b1;
                            base_next       = q_rdata.value;
                            if ((low_wanted != low_held_reg) ||
                                (high_wanted != high_held_reg)) begin
                                state_next = BK_KEYS;
                            end
                        end
                        default: begin
                            // wheel or tap movement
                            wheel_next      = (q_rdata.kind == CMD_WHEEL);
                            base_next       = q_rdata.value;
                            base_valid_next = 1'b1;
                            if (base_valid_reg) begin
                                work_next  = sum;
                                cnt_next   = '0;
                                state_next = BK_MOVE;
                            end
                        end
                    endcase
                end
            end

            BK_KEYS: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (pend_low_reg) begin
                        ev_kind       = low_kind_reg;
                        ev_slot       = SLOT_LOW;
                        ev_last       = !pend_high_reg;
                        pend_low_next = 1'b0;
                        if (!pend_high_reg) begin
                            state_next = BK_IDLE;
                        end
                    end else begin
                        ev_kind        = high_kind_reg;
                        ev_slot        = SLOT_HIGH;
                        ev_last        = 1'b1;
                        pend_high_next = 1'b0;
                        state_next     = BK_IDLE;
                    end
                end
            end

            BK_MOVE: begin
                if (pos_go) begin
                    if (out_free) begin
                        emit      = 1'b1;
                        ev_kind   = wheel_reg ? EV_WHEEL : EV_TAP;
                        ev_slot   = wheel_reg ? SLOT_LOW : SLOT_INC;
                        ev_up     = wheel_reg && !cfg.invert_wheel;
                        ev_last   = (work_sub < step_w) || cap_last;
                        work_next = work_sub;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end else if (neg_go) begin
                    if (out_free) begin
                        emit      = 1'b1;
                        ev_kind   = wheel_reg ? EV_WHEEL : EV_TAP;
                        ev_slot   = wheel_reg ? SLOT_LOW : SLOT_DEC;
                        ev_up     = wheel_reg && cfg.invert_wheel;
                        ev_last   = (work_add2 > 0) || cap_last;
                        work_next = work_add;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end else begin
                    // commit the remainder, saturated to the accumulator width
                    if (work_reg > WORK_W'(127)) begin
                        acc_next = 8'sd127;
                    end else if (work_reg < -WORK_W'(128)) begin
                        acc_next = -8'sd128;
                    end else begin
                        acc_next = work_reg[ACC_W-1:0];
                    end
                    state_next = BK_IDLE;
                end
            end

            default: begin
                state_next = BK_IDLE;
            end
        endcase

        // a write to a known register restarts movement tracking
        if (cfg_clear) begin
            base_valid_next = 1'b0;
            acc_next        = '0;
        end
    end

    // State register and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            low_held_reg   <= 1'b0;
            high_held_reg  <= 1'b0;
            base_valid_reg <= 1'b0;
            base_reg       <= '0;
            acc_reg        <= '0;
            pend_low_reg   <= 1'b0;
            pend_high_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            low_held_reg   <= low_held_next;
            high_held_reg  <= high_held_next;
            base_valid_reg <= base_valid_next;
            base_reg       <= base_next;
            acc_reg        <= acc_next;
            pend_low_reg   <= pend_low_next;
            pend_high_reg  <= pend_high_next;
        end
    end

    // Working registers of the current item
    always_ff @(posedge aclk) begin
        work_reg      <= work_next;
        wheel_reg     <= wheel_next;
        cnt_reg       <= cnt_next;
        low_kind_reg  <= low_kind_next;
        high_kind_reg <= high_kind_next;
    end

    // Output register: loads on emit, empties on a transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_kind_reg <= ev_kind;
            out_slot_reg <= ev_slot;
            out_up_reg   <= ev_up;
            out_last_reg <= ev_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_up_reg, out_slot_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: sv/knob_value_to_key_and_wheel_events.sv
`timescale 1ns / 1ps

// Knob sample to key and wheel event converter.
//
// Input stream: s_tdata carries a 7-bit knob sample, s_tuser selects a
// sample (0) or a release of held keys and tracking (1). Output stream:
// one transfer per event, kind on m_tuser, key slot and wheel direction on
// m_tdata, m_tlast on the final event caused by an input item.
// Registers are to be written through cfg_we/cfg_addr/cfg_wdata only while
// no item is in flight; the block does not enforce this. Any write to a
// known register restarts movement tracking. The first event of an item
// passes through the command queue and the sequencer state register into
// the output register. The back end then issues one event per cycle while
// the output register is free, up to 64 per item, and in wheel and tap
// modes, once the baseline is set, commits the accumulator in a final
// step. A two-entry command queue lets the input side take items while
// the back end works.
// Reset (synchronous, aresetn low) loads the register defaults, drops
// held keys and tracking and empties queue and output register.
// When the receiver stalls, the event waits in the output register and the
// sequencer holds; the input keeps filling the queue until it is full.

module knob_value_to_key_and_wheel_events import kvkw_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [6:0] sample_value, [7] zero
    input  logic                  s_tuser,    // [0] operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,    // [1:0] key_slot, [2] wheel_up, [7:3] zero
    output logic [1:0]            m_tuser,    // [1:0] event_kind
    output logic                  m_tlast,    // last_of_run
    input  logic                  cfg_we,
    input  logic [ADDR_W-1:0]     cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t       cfg_reg;
    logic       cfg_clear;
    q_status_t  q_status;
    logic       q_push;
    logic       q_pop;
    cmd_t       q_wdata;
    cmd_t       q_rdata;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode         <= MODE_NONE;
            cfg_reg.low_level    <= 8'd32;
            cfg_reg.high_level   <= 7'd96;
            cfg_reg.invert_wheel <= 1'b0;
            cfg_reg.wheel_step   <= 7'd8;
            cfg_reg.tap_step     <= 7'd8;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MODE:         cfg_reg.mode         <= mode_t'(cfg_wdata[1:0]);
                REG_LOW_LEVEL:    cfg_reg.low_level    <= cfg_wdata;
                REG_HIGH_LEVEL:   cfg_reg.high_level   <= cfg_wdata[SAMPLE_W-1:0];
                REG_INVERT_WHEEL: cfg_reg.invert_wheel <= cfg_wdata[0];
                REG_WHEEL_STEP:   cfg_reg.wheel_step   <= cfg_wdata[SAMPLE_W-1:0];
                REG_TAP_STEP:     cfg_reg.tap_step     <= cfg_wdata[SAMPLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Writes to known registers restart tracking
    assign cfg_clear = cfg_we && (cfg_addr <= REG_TAP_STEP);

    kvkw_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .mode     (cfg_reg.mode),
        .q_status (q_status),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    kvkw_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .status  (q_status)
    );

    kvkw_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cfg_clear (cfg_clear),
        .q_status  (q_status),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: sv/kvkw_checker.sv
`timescale 1ns / 1ps
`include "knob_value_to_key_and_wheel_events_macros.svh"

module kvkw_checker import kvkw_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // A held event stays offered, unchanged, until it is taken
    `KVKW_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "event dropped or changed while stalled")

    // Reset empties the output register on the next cycle
    `KVKW_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

    // Wheel events carry slot zero
    `KVKW_ASSERT(a_wheel_slot, aclk, aresetn, m_tvalid && (m_tuser == EV_WHEEL) |-> (m_tdata[1:0] == SLOT_LOW), "wheel event with nonzero slot")

    // Key events never carry a wheel direction; taps use the increase or decrease slot
    `KVKW_ASSERT(a_key_noup, aclk, aresetn, m_tvalid && (m_tuser != EV_WHEEL) |-> !m_tdata[2], "key event with wheel direction")

    `KVKW_ASSERT(a_tap_slot, aclk, aresetn, m_tvalid && (m_tuser == EV_TAP) |-> (m_tdata[1:0] == SLOT_INC) || (m_tdata[1:0] == SLOT_DEC), "tap with a threshold key slot")

endmodule

bind knob_value_to_key_and_wheel_events kvkw_checker u_kvkw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: tb/sv/tb_knob_value_to_key_and_wheel_events.sv
`timescale 1ns / 1ps

module tb_knob_value_to_key_and_wheel_events;
    import kvkw_pkg::*;

    localparam int SETTLE_CYCLES    = 24;    // sequencer drain for items with no event
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int NUM_PHASES       = 12;
    localparam int PHASE_ITEMS      = 40;
    localparam int IDLE_PHASE_ITEMS = 8;
    localparam int HOLD_PHASE       = 4;
    localparam int DRAIN_PHASE      = 7;
    localparam int QUIET_FROM_PHASE = 10;

    // index with no register behind it
    localparam logic [ADDR_W-1:0] REG_UNUSED = 3'd6;

    typedef struct packed {
        event_kind_t kind;
        key_slot_t   slot;
        logic        up;
        logic        last;
    } knob_event_t;

    // one row of the directed plan: a register write or an input item
    typedef struct packed {
        logic                  is_write;
        logic [ADDR_W-1:0]     addr;
        logic [CFG_DATA_W-1:0] wdata;
        op_t                   op;
        logic [SAMPLE_W-1:0]   value;
        logic                  typed;
        logic [6:0]            typed_n;
        event_kind_t           typed_kind;
        key_slot_t             typed_slot;
    } plan_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'd0;     // [6:0] sample_value, [7] zero
    logic                  s_tuser   = 1'b0;     // [0] operation
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;              // [1:0] key_slot, [2] wheel_up, [7:3] zero
    logic [1:0]            m_tuser;              // [1:0] event_kind
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [ADDR_W-1:0]     cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    knob_value_to_key_and_wheel_events dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor copy of the registers
    mode_t               knob_mode;
    logic [7:0]          low_thresh;
    logic [SAMPLE_W-1:0] high_thresh;
    logic                invert_dir;
    logic [SAMPLE_W-1:0] wheel_step_reg;
    logic [SAMPLE_W-1:0] tap_step_reg;

    // predictor copy of the tracking state
    logic                low_held;
    logic                high_held;
    logic                base_valid;
    logic [SAMPLE_W-1:0] base_value;
    int                  move_acc;

    knob_event_t run_events[$];       // events of the item being predicted
    knob_event_t pending_events[$];   // predicted, not yet seen on the output
    knob_event_t head_event;
    plan_row_t   plan_rows[$];

    int  error_count   = 0;
    int  items_sent    = 0;
    int  events_seen   = 0;
    int  reg_writes    = 0;
    int  long_holds    = 0;
    int  kind_seen[4];
    int  rx_stall_left = 0;
    int  quiet_cycles  = 0;
    bit  idle_enable   = 1'b1;
    bit  hold_request  = 1'b0;

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 40) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    task automatic add_event(input event_kind_t kind, input key_slot_t slot, input logic up);
        if (run_events.size() < MAX_EVENTS) begin
            run_events.push_back('{kind, slot, up, 1'b0});
        end
    endtask

    task automatic reset_predictor();
        knob_mode      = MODE_NONE;
        low_thresh     = 8'd32;
        high_thresh    = 7'd96;
        invert_dir     = 1'b0;
        wheel_step_reg = 7'd8;
        tap_step_reg   = 7'd8;
        low_held       = 1'b0;
        high_held      = 1'b0;
        base_valid     = 1'b0;
        base_value     = '0;
        move_acc       = 0;
    endtask

    // register write into the predictor; an unused index changes nothing
    task automatic apply_reg_write(input logic [ADDR_W-1:0] addr,
                                   input logic [CFG_DATA_W-1:0] data);
        case (addr)
            REG_MODE:         knob_mode      = mode_t'(data[1:0]);
            REG_LOW_LEVEL:    low_thresh     = data;
            REG_HIGH_LEVEL:   high_thresh    = data[SAMPLE_W-1:0];
            REG_INVERT_WHEEL: invert_dir     = data[0];
            REG_WHEEL_STEP:   wheel_step_reg = data[SAMPLE_W-1:0];
            REG_TAP_STEP:     tap_step_reg   = data[SAMPLE_W-1:0];
            default:          return;
        endcase
        base_valid = 1'b0;
        move_acc   = 0;
    endtask

    // wheel and tap modes: accumulate movement, one event per full step
    task automatic track_movement(input logic [SAMPLE_W-1:0] v, input bit wheel);
        int step_size;
        int acc;
        step_size = wheel ? int'(wheel_step_reg) : int'(tap_step_reg);
        if (step_size < int'(MIN_STEP)) begin
            step_size = int'(MIN_STEP);
        end
        if (!base_valid) begin
            base_valid = 1'b1;
            base_value = v;
            return;
        end
        acc = move_acc + int'(v) - int'(base_value);
        while (acc >= step_size && run_events.size() < MAX_EVENTS) begin
            if (wheel) add_event(EV_WHEEL, SLOT_LOW, !invert_dir);
            else       add_event(EV_TAP, SLOT_INC, 1'b0);
            acc -= step_size;
        end
        while (acc <= -step_size && run_events.size() < MAX_EVENTS) begin
            if (wheel) add_event(EV_WHEEL, SLOT_LOW, invert_dir);
            else       add_event(EV_TAP, SLOT_DEC, 1'b0);
            acc += step_size;
        end
        if (acc > 127)  acc = 127;
        if (acc < -128) acc = -128;
        move_acc   = acc;
        base_value = v;
    endtask

    // events caused by one accepted item, queued behind older ones
    task automatic predict_item(input op_t op, input logic [SAMPLE_W-1:0] v);
        bit low_wanted;
        bit high_wanted;
        run_events.delete();
        if (op == OP_RELEASE) begin
            if (low_held) begin
                add_event(EV_RELEASE, SLOT_LOW, 1'b0);
                low_held = 1'b0;
            end
            if (high_held) begin
                add_event(EV_RELEASE, SLOT_HIGH, 1'b0);
                high_held = 1'b0;
            end
            base_valid = 1'b0;
            move_acc   = 0;
        end else if (knob_mode == MODE_THRESH) begin
            low_wanted  = ({1'b0, v} < low_thresh);
            high_wanted = (v > high_thresh);
            if (low_wanted != low_held) begin
                add_event(low_wanted ? EV_PRESS : EV_RELEASE, SLOT_LOW, 1'b0);
                low_held = low_wanted;
            end
            if (high_wanted != high_held) begin
                add_event(high_wanted ? EV_PRESS : EV_RELEASE, SLOT_HIGH, 1'b0);
                high_held = high_wanted;
            end
            base_valid = 1'b1;
            base_value = v;
        end else if (knob_mode == MODE_WHEEL) begin
            track_movement(v, 1'b1);
        end else if (knob_mode == MODE_TAP) begin
            track_movement(v, 1'b0);
        end
        if (run_events.size() > 0) begin
            run_events[run_events.size()-1].last = 1'b1;
        end
        foreach (run_events[i]) pending_events.push_back(run_events[i]);
    endtask

    // all drive tasks start and end at a falling edge
    task automatic send_item(input op_t op, input logic [SAMPLE_W-1:0] v);
        s_tuser  = op;
        s_tdata  = {1'b0, v};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(op, v);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic sender_gap();
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_events.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        @(posedge aclk);
        apply_reg_write(addr, data);
        reg_writes++;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic plan_write(input logic [ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row          = '0;
        row.is_write = 1'b1;
        row.addr     = addr;
        row.wdata    = data;
        plan_rows.push_back(row);
    endtask

    task automatic plan_item(input op_t op, input logic [SAMPLE_W-1:0] v, input logic typed,
                             input int n, input event_kind_t kind, input key_slot_t slot);
        plan_row_t row;
        row            = '0;
        row.op         = op;
        row.value      = v;
        row.typed      = typed;
        row.typed_n    = n[6:0];
        row.typed_kind = kind;
        row.typed_slot = slot;
        plan_rows.push_back(row);
    endtask

    // random register value, extremes now and then, small steps preferred
    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [ADDR_W-1:0] addr);
        case (addr)
            REG_LOW_LEVEL: begin
                if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'd128 : 8'd0;
                return CFG_DATA_W'($urandom_range(0, 128));
            end
            REG_HIGH_LEVEL: begin
                if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'd127 : 8'd0;
                return CFG_DATA_W'($urandom_range(0, 127));
            end
            REG_INVERT_WHEEL: return CFG_DATA_W'($urandom_range(0, 1));
            default: begin
                case ($urandom_range(0, 11))
                    0:       return 8'd0;
                    1:       return 8'd1;
                    2:       return 8'd127;
                    3:       return CFG_DATA_W'($urandom_range(2, 127));
                    default: return CFG_DATA_W'($urandom_range(2, 16));
                endcase
            end
        endcase
    endfunction

    // result side: random stalls, one long hold on request
    always @(negedge aclk) begin
        if (hold_request) begin
            m_tready = 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge aclk);
            hold_request = 1'b0;
            long_holds++;
        end else if (!idle_enable) begin
            m_tready = 1'b1;
        end else if (rx_stall_left > 0) begin
            m_tready = 1'b0;
            rx_stall_left--;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready = 1'b0;
            rx_stall_left = $urandom_range(1, 18) - 1;
        end else begin
            m_tready = 1'b1;
        end
    end

    // compare each output transfer with the oldest predicted event
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            events_seen++;
            kind_seen[m_tuser]++;
            if (pending_events.size() == 0) begin
                report_error($sformatf("event with none predicted: kind %0d tdata %0h last %0b",
                                       m_tuser, m_tdata, m_tlast));
            end else begin
                head_event = pending_events.pop_front();
                if (m_tuser !== head_event.kind)
                    report_error($sformatf("event_kind %0d, predicted %0d",
                                           m_tuser, head_event.kind));
                if (m_tdata[1:0] !== head_event.slot)
                    report_error($sformatf("key_slot %0d, predicted %0d",
                                           m_tdata[1:0], head_event.slot));
                if (m_tdata[2] !== head_event.up)
                    report_error($sformatf("wheel_up %0b, predicted %0b",
                                           m_tdata[2], head_event.up));
                if (m_tlast !== head_event.last)
                    report_error($sformatf("last_of_run %0b, predicted %0b",
                                           m_tlast, head_event.last));
            end
        end
    end

    // watchdog: cycles without any transfer or register write
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles, %0d events still predicted",
                     quiet_cycles, pending_events.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        mode_t phase_modes [NUM_PHASES];
        plan_row_t row;
        int knob_pos;
        int batch;
        int r;

        phase_modes = '{MODE_WHEEL, MODE_THRESH, MODE_TAP, MODE_NONE, MODE_WHEEL, MODE_TAP,
                        MODE_THRESH, MODE_WHEEL, MODE_TAP, MODE_THRESH, MODE_WHEEL, MODE_TAP};
        foreach (kind_seen[i]) kind_seen[i] = 0;
        reset_predictor();

        // directed plan: mode none, threshold keys, wheel and tap extremes
        plan_item(OP_SAMPLE, 7'd0, 1'b1, 0, EV_PRESS, SLOT_LOW);
        plan_item(OP_RELEASE, 7'd127, 1'b1, 0, EV_PRESS, SLOT_LOW);
        plan_write(REG_MODE, {6'd0, MODE_THRESH});
        plan_item(OP_SAMPLE, 7'd0, 1'b1, 1, EV_PRESS, SLOT_LOW);
        plan_item(OP_SAMPLE, 7'd127, 1'b1, 2, EV_RELEASE, SLOT_LOW);
        plan_item(OP_SAMPLE, 7'd64, 1'b1, 1, EV_RELEASE, SLOT_HIGH);
        plan_item(OP_SAMPLE, 7'd127, 1'b1, 1, EV_PRESS, SLOT_HIGH);
        plan_item(OP_RELEASE, 7'd0, 1'b1, 1, EV_RELEASE, SLOT_HIGH);
        // threshold extremes: low key always wanted, high key on anything above zero
        plan_write(REG_LOW_LEVEL, 8'd128);
        plan_write(REG_HIGH_LEVEL, 8'd0);
        plan_item(OP_SAMPLE, 7'd0, 1'b1, 1, EV_PRESS, SLOT_LOW);
        plan_item(OP_SAMPLE, 7'd127, 1'b1, 1, EV_PRESS, SLOT_HIGH);
        // both keys stay held across the mode change; small step saturates
        plan_write(REG_MODE, {6'd0, MODE_WHEEL});
        plan_write(REG_WHEEL_STEP, 8'd0);
        plan_item(OP_SAMPLE, 7'd0, 1'b1, 0, EV_WHEEL, SLOT_LOW);
        plan_item(OP_SAMPLE, 7'd127, 1'b1, 63, EV_WHEEL, SLOT_LOW);
        plan_item(OP_SAMPLE, 7'd0, 1'b1, 63, EV_WHEEL, SLOT_LOW);
        plan_item(OP_RELEASE, 7'd85, 1'b1, 2, EV_RELEASE, SLOT_LOW);
        // inverted wheel, largest step
        plan_write(REG_INVERT_WHEEL, 8'd1);
        plan_write(REG_WHEEL_STEP, 8'd127);
        plan_item(OP_SAMPLE, 7'd0, 1'b1, 0, EV_WHEEL, SLOT_LOW);
        plan_item(OP_SAMPLE, 7'd127, 1'b1, 1, EV_WHEEL, SLOT_LOW);
        plan_item(OP_SAMPLE, 7'd0, 1'b1, 1, EV_WHEEL, SLOT_LOW);
        plan_write(REG_WHEEL_STEP, 8'd1);
        plan_write(REG_INVERT_WHEEL, 8'd0);
        plan_item(OP_SAMPLE, 7'd42, 1'b1, 0, EV_WHEEL, SLOT_LOW);
        plan_item(OP_SAMPLE, 7'd45, 1'b0, 0, EV_WHEEL, SLOT_LOW);
        // taps
        plan_write(REG_MODE, {6'd0, MODE_TAP});
        plan_write(REG_TAP_STEP, 8'd1);
        plan_item(OP_SAMPLE, 7'd10, 1'b1, 0, EV_TAP, SLOT_DEC);
        plan_item(OP_SAMPLE, 7'd0, 1'b1, 5, EV_TAP, SLOT_DEC);
        plan_write(REG_TAP_STEP, 8'd127);
        plan_item(OP_SAMPLE, 7'd0, 1'b1, 0, EV_TAP, SLOT_INC);
        plan_item(OP_SAMPLE, 7'd127, 1'b1, 1, EV_TAP, SLOT_INC);
        // write to an unused index keeps the baseline
        plan_write(REG_UNUSED, 8'hff);
        plan_item(OP_SAMPLE, 7'd0, 1'b0, 0, EV_TAP, SLOT_DEC);
        plan_write(REG_MODE, {6'd0, MODE_NONE});
        plan_item(OP_SAMPLE, 7'd5, 1'b1, 0, EV_PRESS, SLOT_LOW);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed part
        foreach (plan_rows[i]) begin
            row = plan_rows[i];
            if (row.is_write) begin
                write_reg(row.addr, row.wdata);
            end else begin
                sender_gap();
                send_item(row.op, row.value);
                if (row.typed && run_events.size() != row.typed_n) begin
                    report_error($sformatf("row %0d: %0d events predicted, table says %0d",
                                           i, run_events.size(), row.typed_n));
                end else if (row.typed && row.typed_n > 0 &&
                             (run_events[0].kind != row.typed_kind ||
                              run_events[0].slot != row.typed_slot)) begin
                    report_error($sformatf("row %0d: first event differs from table", i));
                end
            end
        end

        // random part: one register setting per phase, walk of knob samples
        knob_pos = 64;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            write_reg(REG_MODE, {6'd0, phase_modes[phase]});
            for (int a = REG_LOW_LEVEL; a <= REG_TAP_STEP; a++) begin
                if ($urandom_range(0, 1) == 0) write_reg(a[ADDR_W-1:0], pick_reg_value(a[ADDR_W-1:0]));
            end
            idle_enable = (phase < QUIET_FROM_PHASE) && ($urandom_range(0, 3) != 0);
            batch = (phase_modes[phase] == MODE_NONE) ? IDLE_PHASE_ITEMS : PHASE_ITEMS;
            for (int k = 0; k < batch; k++) begin
                if (phase == HOLD_PHASE && k == 3) hold_request = 1'b1;
                if (phase == DRAIN_PHASE && k == batch / 2) wait_drained();
                sender_gap();
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    send_item(OP_RELEASE, SAMPLE_W'($urandom_range(0, 127)));
                end else begin
                    if (r < 16)      knob_pos = $urandom_range(0, 1) ? 127 : 0;
                    else if (r < 31) knob_pos = $urandom_range(0, 127);
                    else             knob_pos = knob_pos + int'($urandom_range(0, 20)) - 10;
                    if (knob_pos < 0)   knob_pos = 0;
                    if (knob_pos > 127) knob_pos = 127;
                    send_item(OP_SAMPLE, knob_pos[SAMPLE_W-1:0]);
                end
            end
        end

        // drain and let the block run out
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (pending_events.size() != 0) begin
            report_error($sformatf("%0d predicted events never appeared", pending_events.size()));
        end

        $display("Run covered %0d items, %0d register writes and %0d events in all four modes",
                 items_sent, reg_writes, events_seen);
        $display("Events by kind: press %0d, release %0d, tap %0d, wheel %0d; long holds %0d",
                 kind_seen[EV_PRESS], kind_seen[EV_RELEASE], kind_seen[EV_TAP],
                 kind_seen[EV_WHEEL], long_holds);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/kvkw_pkg.sv
sv/kvkw_front.sv
sv/kvkw_cmd_fifo.sv
sv/kvkw_back.sv
sv/knob_value_to_key_and_wheel_events.sv
sv/kvkw_checker.sv
tb/sv/tb_knob_value_to_key_and_wheel_events.sv
